### design/gb3_pkg.sv
// gb3_pkg: shared types, codes and the blur arithmetic for the 3x3 gaussian blur core
// no dependencies; used by every module of the core by scoped names
package gb3_pkg;

  // input item kinds
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // configuration register index, selected by paddr[2]
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_e;

  localparam int unsigned CfgWidthBits  = 12;
  localparam int unsigned CfgHeightBits = 13;
  localparam logic [CfgWidthBits-1:0]  WidthReset  = 12'd640;
  localparam logic [CfgHeightBits-1:0] HeightReset = 13'd480;

  // packed as red in the low byte, alpha in the high byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // per-shift control: whether a result is due and how its window is clamped
  typedef struct packed {
    logic emit;
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic last;
  } edge_t;

  typedef struct packed {
    logic last;
    pix_t pix;
  } res_t;

  // 1-2-1 / 2-4-2 / 1-2-1 weighted sum, divided by 16; never exceeds 255
  function automatic logic [7:0] blur_chan(input logic [8:0][7:0] c);
    logic [11:0] s;
    s = 12'(c[0]) + 12'(c[2]) + 12'(c[6]) + 12'(c[8])
      + (12'(c[1]) << 1) + (12'(c[3]) << 1) + (12'(c[5]) << 1) + (12'(c[7]) << 1)
      + (12'(c[4]) << 2);
    return s[11:4];
  endfunction

endpackage

### design/gb3_ctrl.sv
// gb3_ctrl: raster position counters, result scheduling and edge flags
// depends on gb3_pkg
module gb3_ctrl #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [gb3_pkg::CfgWidthBits-1:0]     cfg_width_i,
  input  logic [gb3_pkg::CfgHeightBits-1:0]    cfg_height_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic                                 b_free_i,
  output logic                                 push_o,
  output logic [XW-1:0]                        addr_o,
  output logic                                 zero_pix_o,
  output gb3_pkg::edge_t                       flags_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = HW + 1;

  logic [CW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [XW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic          pend_q, pend_d;
  logic [XW:0]   col_inc, ocol_inc;
  logic          complete, due, go, do_shift, do_emit, last_col, last_row;

  // register values clamped into the supported range
  always_comb begin
    if (cfg_width_i == '0) begin
      eff_w = CW'(1);
    end else if (32'(cfg_width_i) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(cfg_width_i);
    end
    if (cfg_height_i == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg_height_i) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_height_i);
    end
  end

  assign in_ready_o = b_free_i && !pend_q;

  always_comb begin
    complete = 32'(in_row_q) >= 32'(eff_h);
    due      = (32'(in_row_q) >= 32'd2) || ((32'(in_row_q) == 32'd1) && (in_col_q != '0));
    go       = pend_q ? b_free_i : (in_valid_i && in_ready_o);
    do_shift   = 1'b0;
    do_emit    = 1'b0;
    zero_pix_o = 1'b0;
    pend_d     = pend_q;
    if (go) begin
      if (pend_q) begin
        // second dummy column of a single-row frame's flush
        do_shift   = 1'b1;
        do_emit    = 1'b1;
        zero_pix_o = 1'b1;
        pend_d     = 1'b0;
      end else if (!complete) begin
        if (gb3_pkg::op_e'(op_i) == gb3_pkg::OP_PIXEL) begin
          do_shift = 1'b1;
          do_emit  = due;
        end
      end else begin
        // frame complete: item acts as a flush
        do_shift   = 1'b1;
        zero_pix_o = 1'b1;
        if (due) begin
          do_emit = 1'b1;
        end else begin
          pend_d = 1'b1;
        end
      end
    end

    col_inc  = {1'b0, in_col_q} + (XW + 1)'(1);
    ocol_inc = {1'b0, out_col_q} + (XW + 1)'(1);
    last_col = 32'(out_col_q) >= (32'(eff_w) - 32'd1);
    last_row = 32'(out_row_q) >= (32'(eff_h) - 32'd1);

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (do_shift) begin
      if (32'(col_inc) >= 32'(eff_w)) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = col_inc[XW-1:0];
      end
    end
    if (do_emit) begin
      if (last_col && last_row) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (32'(ocol_inc) >= 32'(eff_w)) begin
        out_col_d = '0;
        out_row_d = out_row_q + RW'(1);
      end else begin
        out_col_d = ocol_inc[XW-1:0];
      end
    end

    flags_o.emit   = do_emit;
    flags_o.left   = (out_col_q == '0);
    flags_o.right  = last_col;
    flags_o.top    = (out_row_q == '0);
    flags_o.bottom = last_row;
    flags_o.last   = last_col && last_row;
  end

  assign push_o = do_shift;
  assign addr_o = in_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
    end
  end

endmodule

### design/gb3_lines.sv
// gb3_lines: upper and lower line stores with registered read and write forwarding
// depends on gb3_pkg
module gb3_lines #(
  parameter int unsigned MAX_WIDTH = 2048,
  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [XW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [XW-1:0] wr_addr_i,
  input  gb3_pkg::pix_t wr_pix_i,
  output gb3_pkg::pix_t up_o,
  output gb3_pkg::pix_t lo_o
);

  gb3_pkg::pix_t upper_mem [MAX_WIDTH];
  gb3_pkg::pix_t lower_mem [MAX_WIDTH];
  gb3_pkg::pix_t rd_up_q, rd_lo_q, fwd_up_q, fwd_lo_q;
  logic          fwd_q;

  // a write in the same cycle as the read is not seen by the ram
  assign up_o = fwd_q ? fwd_up_q : rd_up_q;
  assign lo_o = fwd_q ? fwd_lo_q : rd_lo_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i] <= lo_o;
      lower_mem[wr_addr_i] <= wr_pix_i;
    end
    if (rd_en_i) begin
      rd_up_q  <= upper_mem[rd_addr_i];
      rd_lo_q  <= lower_mem[rd_addr_i];
      fwd_up_q <= lo_o;
      fwd_lo_q <= wr_pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

endmodule

### design/gb3_window.sv
// gb3_window: 3x3 pixel window, edge clamping and the weighted sum
// depends on gb3_pkg
module gb3_window (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  gb3_pkg::pix_t  up_i,
  input  gb3_pkg::pix_t  lo_i,
  input  gb3_pkg::pix_t  pix_i,
  input  gb3_pkg::edge_t flags_i,
  output gb3_pkg::res_t  res_o
);

  gb3_pkg::pix_t  win_q [9];
  gb3_pkg::pix_t  win_n [9];
  gb3_pkg::pix_t  p [9];
  logic [8:0][7:0] ch_r, ch_g, ch_b;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_n[r*3+0] = win_q[r*3+1];
      win_n[r*3+1] = win_q[r*3+2];
    end
    win_n[2] = up_i;
    win_n[5] = lo_i;
    win_n[8] = pix_i;

    p = win_n;
    // columns first, then rows
    for (int r = 0; r < 3; r++) begin
      if (flags_i.left)  p[r*3+0] = win_n[r*3+1];
      if (flags_i.right) p[r*3+2] = win_n[r*3+1];
    end
    for (int k = 0; k < 3; k++) begin
      if (flags_i.top)    p[k]   = p[3+k];
      if (flags_i.bottom) p[6+k] = p[3+k];
    end
    for (int i = 0; i < 9; i++) begin
      ch_r[i] = p[i].red;
      ch_g[i] = p[i].green;
      ch_b[i] = p[i].blue;
    end
    res_o.pix.red   = gb3_pkg::blur_chan(ch_r);
    res_o.pix.green = gb3_pkg::blur_chan(ch_g);
    res_o.pix.blue  = gb3_pkg::blur_chan(ch_b);
    res_o.pix.alpha = p[4].alpha;
    res_o.last      = flags_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_q <= win_n;
    end
  end

endmodule

### design/gaussian_blur_3x3_rgba_stream_core.sv
// gaussian_blur_3x3_rgba_stream_core: 3x3 gaussian blur of a raster rgba stream
// depends on gb3_pkg, gb3_ctrl, gb3_lines, gb3_window
// path: an accepted item passes the shift stage register, then its result
//   goes into the result register; a single-row frame's first flush makes two columns
// throughput: one item per cycle unless a result waits in a full result register; a
//   single-row frame's first flush holds the input for its two shift-stage columns
// reset: asynchronous active low; counters, window and valids clear, line stores do not
module gaussian_blur_3x3_rgba_stream_core #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  alpha_in_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  alpha_out_o,
  output logic        frame_end_o
);

  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration registers
  logic [gb3_pkg::CfgWidthBits-1:0]  cfg_width_q;
  logic [gb3_pkg::CfgHeightBits-1:0] cfg_height_q;
  logic                              cfg_wr;

  // control stage outputs
  logic           push;
  logic [XW-1:0]  push_addr;
  logic           zero_pix;
  gb3_pkg::edge_t push_flags;
  gb3_pkg::pix_t  in_pix;

  // shift stage: one item's column, waiting for its line store read data
  logic           b_valid_q;
  logic [XW-1:0]  b_addr_q;
  gb3_pkg::edge_t b_flags_q;
  gb3_pkg::pix_t  b_pix_q;
  logic           b_proc, b_free;

  // column above the new item, from the line stores
  gb3_pkg::pix_t  col_up, col_lo;
  gb3_pkg::res_t  res;

  // result register
  logic           out_valid_q;
  gb3_pkg::res_t  out_q;

  // ---------------------------------------------------------------------------
  // configuration port: no wait states, reads return the stored value
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= gb3_pkg::WidthReset;
      cfg_height_q <= gb3_pkg::HeightReset;
    end else if (cfg_wr) begin
      case (gb3_pkg::reg_e'(paddr[2]))
        gb3_pkg::REG_FRAME_WIDTH:  cfg_width_q  <= pwdata[gb3_pkg::CfgWidthBits-1:0];
        gb3_pkg::REG_FRAME_HEIGHT: cfg_height_q <= pwdata[gb3_pkg::CfgHeightBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (gb3_pkg::reg_e'(paddr[2]))
      gb3_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_width_q);
      gb3_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_height_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control stage: counters advance as the item is accepted, the line stores
  // are read at the item's column
  // ---------------------------------------------------------------------------
  gb3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (cfg_width_q),
    .cfg_height_i (cfg_height_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .b_free_i     (b_free),
    .push_o       (push),
    .addr_o       (push_addr),
    .zero_pix_o   (zero_pix),
    .flags_o      (push_flags)
  );

  // flushes and pixels past the frame shift in an empty column
  always_comb begin
    in_pix.red   = red_in_i;
    in_pix.green = green_in_i;
    in_pix.blue  = blue_in_i;
    in_pix.alpha = alpha_in_i;
    if (zero_pix) begin
      in_pix = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // shift stage: the window takes the column and the result is formed; a
  // column that yields no result moves on even while the result register is full
  // ---------------------------------------------------------------------------
  assign b_proc = b_valid_q && (!b_flags_q.emit || !out_valid_q || out_ready_i);
  assign b_free = !b_valid_q || b_proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (push) begin
      b_valid_q <= 1'b1;
    end else if (b_proc) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      b_addr_q  <= push_addr;
      b_flags_q <= push_flags;
      b_pix_q   <= in_pix;
    end
  end

  gb3_lines #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lines (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (push),
    .rd_addr_i (push_addr),
    .wr_en_i   (b_proc),
    .wr_addr_i (b_addr_q),
    .wr_pix_i  (b_pix_q),
    .up_o      (col_up),
    .lo_o      (col_lo)
  );

  gb3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (b_proc),
    .up_i    (col_up),
    .lo_i    (col_lo),
    .pix_i   (b_pix_q),
    .flags_i (b_flags_q),
    .res_o   (res)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_proc && b_flags_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_proc && b_flags_q.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_q.pix.red;
  assign green_out_o = out_q.pix.green;
  assign blue_out_o  = out_q.pix.blue;
  assign alpha_out_o = out_q.pix.alpha;
  assign frame_end_o = out_q.last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an item is only taken when the shift stage empties in the same cycle
  a_no_stage_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!b_valid_q || b_proc))
    else $error("shift stage overwritten");

  // a column pushed without an accepted item is the second flush column and emits
  a_extra_col_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !(in_valid_i && in_ready_o)) |-> push_flags.emit)
    else $error("extra column without a result");

  // a result leaving the shift stage shows up with its frame end mark
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_proc && b_flags_q.emit) |=> (out_valid_o && (frame_end_o == $past(b_flags_q.last))))
    else $error("result lost on the way to the output");

endmodule

### tb/sv/gaussian_blur_3x3_rgba_stream_core_tb.sv
// gaussian_blur_3x3_rgba_stream_core_tb: self-checking testbench for the 3x3 rgba blur core
// predicts every result item from its own model of the line stores and window
// depends on gb3_pkg and gaussian_blur_3x3_rgba_stream_core
`timescale 1ns / 1ps

module gaussian_blur_3x3_rgba_stream_core_tb;

  localparam int unsigned MAX_W       = 32;
  localparam int unsigned MAX_H       = 32;
  localparam int unsigned DRAIN_GAP   = 20;      // idle margin after the last result
  localparam int unsigned HOLD_CYCLES = 400;     // long back-pressure stretch
  localparam int unsigned CYCLE_LIMIT = 400000;  // upper bound on the whole run

  // one pending input item
  typedef struct packed {
    gb3_pkg::op_e  op;
    gb3_pkg::pix_t px;
  } stim_t;

  logic          clk_i;
  logic          rst_ni     = 1'b0;
  logic          psel       = 1'b0;
  logic          penable    = 1'b0;
  logic          pwrite     = 1'b0;
  logic [2:0]    paddr      = '0;
  logic [31:0]   pwdata     = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid   = 1'b0;
  logic          in_ready_o;
  gb3_pkg::op_e  op_d       = gb3_pkg::OP_PIXEL;
  gb3_pkg::pix_t px_d       = '0;
  logic          out_valid_o;
  logic          out_ready  = 1'b0;
  logic [7:0]    red_out_o;
  logic [7:0]    green_out_o;
  logic [7:0]    blue_out_o;
  logic [7:0]    alpha_out_o;
  logic          frame_end_o;

  gaussian_blur_3x3_rgba_stream_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .op_i       (op_d),
    .red_in_i   (px_d.red),
    .green_in_i (px_d.green),
    .blue_in_i  (px_d.blue),
    .alpha_in_i (px_d.alpha),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .alpha_out_o(alpha_out_o),
    .frame_end_o(frame_end_o)
  );

  // ---------------------------------------------------------------------------
  // shared testbench state
  // ---------------------------------------------------------------------------
  stim_t           pixel_q[$];        // items waiting for the driver
  gb3_pkg::res_t   blurred_q[$];      // predicted result items, oldest first
  int unsigned errors      = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned rand_items  = 0;   // non-ignored items sent by the random frames
  int unsigned send_idle   = 0;   // percent of cycles the sender holds back
  int unsigned recv_idle   = 0;   // percent of cycles the receiver holds back
  int unsigned hold_req    = 0;   // bumped by the sequence to ask for a long stall
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  // ---------------------------------------------------------------------------
  // blur predictor: own copy of configuration, line stores, window and counters
  // ---------------------------------------------------------------------------
  logic [11:0]   cfg_width  = gb3_pkg::WidthReset;
  logic [12:0]   cfg_height = gb3_pkg::HeightReset;
  gb3_pkg::pix_t upper_row [0:MAX_W-1];
  gb3_pkg::pix_t lower_row [0:MAX_W-1];
  gb3_pkg::pix_t win [0:8];          // row-major, column 2 is the newest
  int unsigned in_col  = 0;
  int unsigned in_row  = 0;
  int unsigned out_col = 0;
  int unsigned out_row = 0;

  // register values are clamped into the supported frame size
  function automatic int unsigned used_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_W) return MAX_W;
    return 32'(cfg_width);
  endfunction

  function automatic int unsigned used_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > MAX_H) return MAX_H;
    return 32'(cfg_height);
  endfunction

  // 1-2-1 / 2-4-2 / 1-2-1 taps, sum divided by 16
  function automatic logic [7:0] gauss_tap_sum(input logic [8:0][7:0] t);
    logic [11:0] acc;
    acc = '0;
    for (int k = 0; k < 9; k++) begin
      if (k == 4) acc = acc + ({4'b0, t[k]} << 2);
      else if (k % 2 == 1) acc = acc + ({4'b0, t[k]} << 1);
      else acc = acc + {4'b0, t[k]};
    end
    return acc[11:4];
  endfunction

  // move one column into the window and the line stores; true if a result is due
  function automatic bit shift_column_in(input gb3_pkg::pix_t px);
    int unsigned   c;
    gb3_pkg::pix_t up;
    gb3_pkg::pix_t lo;
    bit            due;
    c  = in_col;
    up = '0;
    lo = '0;
    if (c < MAX_W) begin
      up           = upper_row[c];
      lo           = lower_row[c];
      upper_row[c] = lo;
      lower_row[c] = px;
    end
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = up;
    win[5] = lo;
    win[8] = px;
    due    = (in_row >= 2) || (in_row == 1 && c >= 1);
    in_col = c + 1;
    if (in_col >= used_width()) begin
      in_col = 0;
      in_row = in_row + 1;
    end
    return due;
  endfunction

  // blur the window at the current output position, with edge clamping
  task automatic emit_blurred();
    gb3_pkg::pix_t   p [0:8];
    int unsigned     w;
    int unsigned     h;
    logic [8:0][7:0] tr;
    logic [8:0][7:0] tg;
    logic [8:0][7:0] tb;
    gb3_pkg::res_t   res;
    w = used_width();
    h = used_height();
    for (int k = 0; k < 9; k++) p[k] = win[k];
    for (int r = 0; r < 3; r++) begin
      if (out_col == 0) p[r*3] = p[r*3+1];
      if (out_col >= w - 1) p[r*3+2] = p[r*3+1];
    end
    for (int k = 0; k < 3; k++) begin
      if (out_row == 0) p[k] = p[3+k];
      if (out_row >= h - 1) p[6+k] = p[3+k];
    end
    for (int k = 0; k < 9; k++) begin
      tr[k] = p[k].red;
      tg[k] = p[k].green;
      tb[k] = p[k].blue;
    end
    res.pix.red   = gauss_tap_sum(tr);
    res.pix.green = gauss_tap_sum(tg);
    res.pix.blue  = gauss_tap_sum(tb);
    res.pix.alpha = p[4].alpha;
    if (out_col >= w - 1 && out_row >= h - 1) begin
      res.last = 1'b1;
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
    end else begin
      res.last = 1'b0;
      out_col  = out_col + 1;
      if (out_col >= w) begin
        out_col = 0;
        out_row = out_row + 1;
      end
    end
    blurred_q.insert(blurred_q.size(), res);
  endtask

  // one accepted input item
  task automatic predict_blur(input gb3_pkg::op_e op, input gb3_pkg::pix_t px);
    if (in_row < used_height()) begin
      // frame still filling: flushes are ignored
      if (op == gb3_pkg::OP_PIXEL) begin
        if (shift_column_in(px)) emit_blurred();
      end
    end else begin
      // frame complete: any item drains one result, a pixel's data are dropped
      if (!shift_column_in('0)) void'(shift_column_in('0));
      emit_blurred();
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("gaussian_blur_3x3_rgba_stream_core_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: offers queued items, holds each one until it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_items
    stim_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) predict_blur(op_d, px_d);
      // a new item only once the current one has gone
      if (!in_valid || in_ready_o) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          nxt      = pixel_q.pop_front();
          op_d     <= nxt.op;
          px_d     <= nxt.px;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted result and drives ready, with the long stall
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors = errors + 1;
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    gb3_pkg::res_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (blurred_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual %0h %0h %0h %0h %0b",
                   $time, red_out_o, green_out_o, blue_out_o, alpha_out_o, frame_end_o);
          errors = errors + 1;
        end else begin
          want = blurred_q.pop_front();
          check_field("red_out", want.pix.red, red_out_o);
          check_field("green_out", want.pix.green, green_out_o);
          check_field("blue_out", want.pix.blue, blue_out_o);
          check_field("alpha_out", want.pix.alpha, alpha_out_o);
          check_field("frame_end", {7'b0, want.last}, {7'b0, frame_end_o});
        end
      end
      // long hold-off counted here, the sender keeps offering meanwhile
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input gb3_pkg::reg_e idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write a register, mirror it in the predictor, then read it back
  task automatic set_register(input gb3_pkg::reg_e idx, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    if (idx == gb3_pkg::REG_FRAME_WIDTH) begin
      cfg_width = val[11:0];
      want      = {20'b0, cfg_width};
    end else begin
      cfg_height = val[12:0];
      want       = {19'b0, cfg_height};
    end
    apb_access(1'b1, idx, val, rd);
    apb_access(1'b0, idx, '0, rd);
    if (rd !== want) begin
      $display("%0t: register %s readback, expected %0h, actual %0h",
               $time, idx.name(), want, rd);
      errors = errors + 1;
    end
  endtask

  task automatic set_frame_size(input logic [31:0] w, input logic [31:0] h);
    set_register(gb3_pkg::REG_FRAME_WIDTH, w);
    set_register(gb3_pkg::REG_FRAME_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // nothing queued, nothing in flight, then an idle gap for the pipeline
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || blurred_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned s, input int unsigned r);
    @(negedge clk_i);
    send_idle = s;
    recv_idle = r;
  endtask

  task automatic push_item(input gb3_pkg::op_e op, input gb3_pkg::pix_t px);
    stim_t s;
    s.op = op;
    s.px = px;
    pixel_q.insert(pixel_q.size(), s);
  endtask

  function automatic gb3_pkg::pix_t px_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] a);
    gb3_pkg::pix_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    return p;
  endfunction

  // mostly uniform, sometimes the channel extremes
  function automatic logic [7:0] rand_chan();
    logic [7:0] v;
    if ($urandom_range(9) == 0) v = $urandom_range(1) ? 8'hff : 8'h00;
    else v = 8'($urandom_range(255));
    return v;
  endfunction

  function automatic gb3_pkg::pix_t rand_pix();
    return px_of(rand_chan(), rand_chan(), rand_chan(), rand_chan());
  endfunction

  // whole frame in raster order, with stray early flushes and pixels in the drain
  task automatic send_frame(input int unsigned w, input int unsigned h);
    int unsigned n_drain;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(24) == 0) push_item(gb3_pkg::OP_FLUSH, rand_pix());
      push_item(gb3_pkg::OP_PIXEL, rand_pix());
    end
    // a single-row frame has one result fewer still pending
    n_drain = (h == 1) ? w : w + 1;
    for (int unsigned i = 0; i < n_drain; i++)
      push_item(($urandom_range(7) == 0) ? gb3_pkg::OP_PIXEL : gb3_pkg::OP_FLUSH, rand_pix());
    if ($urandom_range(3) == 0) push_item(gb3_pkg::OP_FLUSH, rand_pix());
    rand_items = rand_items + w * h + n_drain;
  endtask

  // random phases of frames, small sizes mostly
  task automatic run_random(input int unsigned budget);
    int unsigned goal;
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    goal = rand_items + budget;
    while (rand_items < goal) begin
      case ($urandom_range(19))
        0:       w = $urandom_range(MAX_W, 25);
        1, 2, 3: w = $urandom_range(24, 7);
        default: w = $urandom_range(6, 1);
      endcase
      h = ($urandom_range(4) == 0) ? $urandom_range(10, 6) : $urandom_range(5, 1);
      wait_idle();
      set_frame_size(w, h);
      @(negedge clk_i);
      frames = $urandom_range(3, 1);
      for (int unsigned f = 0; f < frames; f++) send_frame(w, h);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
    for (int k = 0; k < 9; k++) win[k] = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // sender idles now and then, receiver about half the time
    set_idling(17, 53);

    // 3x2 frame: channel extremes, alternating bits, an early flush that does
    // nothing, and a pixel in the drain that only counts as a flush
    set_frame_size(3, 2);
    @(negedge clk_i);
    push_item(gb3_pkg::OP_PIXEL, px_of(8'h00, 8'h00, 8'h00, 8'h00));
    push_item(gb3_pkg::OP_PIXEL, px_of(8'hff, 8'hff, 8'hff, 8'hff));
    push_item(gb3_pkg::OP_PIXEL, px_of(8'haa, 8'h55, 8'haa, 8'h55));
    push_item(gb3_pkg::OP_FLUSH, px_of(8'hff, 8'hff, 8'hff, 8'hff));
    push_item(gb3_pkg::OP_PIXEL, px_of(8'h55, 8'haa, 8'h55, 8'haa));
    push_item(gb3_pkg::OP_PIXEL, px_of(8'hff, 8'h00, 8'hff, 8'h00));
    push_item(gb3_pkg::OP_PIXEL, px_of(8'h00, 8'hff, 8'h00, 8'hff));
    push_item(gb3_pkg::OP_FLUSH, px_of(8'h00, 8'h00, 8'h00, 8'h00));
    push_item(gb3_pkg::OP_PIXEL, px_of(8'h12, 8'h34, 8'h56, 8'h78));
    push_item(gb3_pkg::OP_FLUSH, px_of(8'h00, 8'h00, 8'h00, 8'h00));
    push_item(gb3_pkg::OP_FLUSH, px_of(8'h00, 8'h00, 8'h00, 8'h00));

    // single-row frame: first flush shifts two dummy columns
    wait_idle();
    set_frame_size(2, 1);
    @(negedge clk_i);
    push_item(gb3_pkg::OP_PIXEL, px_of(8'hff, 8'h80, 8'h01, 8'hfe));
    push_item(gb3_pkg::OP_PIXEL, px_of(8'h01, 8'h7f, 8'hff, 8'h02));
    push_item(gb3_pkg::OP_FLUSH, px_of(8'h00, 8'h00, 8'h00, 8'h00));
    push_item(gb3_pkg::OP_FLUSH, px_of(8'h00, 8'h00, 8'h00, 8'h00));

    // one pixel frame, every neighbour clamped to the centre
    wait_idle();
    set_frame_size(1, 1);
    @(negedge clk_i);
    push_item(gb3_pkg::OP_PIXEL, px_of(8'hc3, 8'h3c, 8'h99, 8'h66));
    push_item(gb3_pkg::OP_FLUSH, px_of(8'h00, 8'h00, 8'h00, 8'h00));

    // height lowered mid-frame: two rows in, then the frame is cut to two rows
    wait_idle();
    set_frame_size(3, 4);
    @(negedge clk_i);
    for (int i = 0; i < 6; i++) push_item(gb3_pkg::OP_PIXEL, rand_pix());
    wait_idle();
    set_register(gb3_pkg::REG_FRAME_HEIGHT, 2);
    @(negedge clk_i);
    for (int i = 0; i < 4; i++) push_item(gb3_pkg::OP_FLUSH, rand_pix());

    // random frames; a long output stall early on fills the block
    wait_idle();
    set_frame_size(5, 8);
    @(negedge clk_i);
    send_frame(5, 8);
    send_frame(5, 8);
    hold_req = hold_req + 1;
    run_random(40);

    set_idling(53, 17);
    run_random(60);

    // no idling on either side from here on
    set_idling(0, 0);
    run_random(60);

    // widest rows: every line store entry written and read
    wait_idle();
    set_frame_size(MAX_W, 2);
    @(negedge clk_i);
    send_frame(MAX_W, 2);

    // tallest frame, one column wide
    wait_idle();
    set_frame_size(1, MAX_H);
    @(negedge clk_i);
    send_frame(1, MAX_H);

    wait_idle();
    if (errors == 0) begin
      $display("gaussian_blur_3x3_rgba_stream_core_tb: PASS");
    end else begin
      $display("gaussian_blur_3x3_rgba_stream_core_tb: FAIL");
    end
    $finish;
  end

endmodule
